[rtl/sds_pkg.sv]
// Shared types and constants of the SCAN disk scheduler.
// No dependencies; every other file depends on this package.
`default_nettype none

package sds_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
	localparam int CYL_W        = 12;
	localparam int SEEK_W       = 19;
	localparam int KEY_W        = CYL_W + 1;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W    = 1;

	typedef logic [CYL_W-1:0]     cyl_t;
	typedef logic [SEEK_W-1:0]    seek_t;
	typedef logic [KEY_W-1:0]     key_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_START_HEAD = 1'b0;
	localparam cfg_idx_t REG_MAX_CYL    = 1'b1;

	localparam cyl_t MAX_CYL_RESET = CYL_W'(199);

	// Sort key: upper requests {0, cyl} ascending, lower requests {1, ~cyl}
	// so that plain ascending key order is the service order.
	typedef struct packed {
		key_t key;
		logic last;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_xfer_t;

	function automatic cyl_t key_to_cyl(input key_t key);
		return key[KEY_W-1] ? ~key[CYL_W-1:0] : key[CYL_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/sds_ifs.sv]
// Valid/ready channel interfaces of the scheduler: requests in, visits out.
// Depends on sds_pkg for field types.
`default_nettype none

interface sds_req_if;
	logic          valid;
	logic          ready;
	sds_pkg::cyl_t cylinder;
	logic          last_request;

	modport source (output valid, cylinder, last_request, input ready);
	modport sink (input valid, cylinder, last_request, output ready);
endinterface

interface sds_visit_if;
	logic           valid;
	logic           ready;
	sds_pkg::cyl_t  visit_cylinder;
	sds_pkg::seek_t total_seek;
	logic           is_turn_point;
	logic           last_visit;

	modport source (output valid, visit_cylinder, total_seek, is_turn_point, last_visit,
		input ready);
	modport sink (input valid, visit_cylinder, total_seek, is_turn_point, last_visit,
		output ready);
endinterface

`default_nettype wire

[rtl/sds_front.sv]
// Front stage: accepts requests and classifies each against the start head
// into a sort key. Depends on sds_pkg and sds_req_if.
`default_nettype none

module sds_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	sds_req_if.sink               req,
	input  wire sds_pkg::cyl_t    start_head,
	output sds_pkg::q_xfer_t      push,
	input  wire logic             push_ready
);
	import sds_pkg::*;

	logic    vld_s1;
	q_item_t item_s1;
	logic    take;

	assign req.ready = !vld_s1 || push_ready;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.last <= req.last_request;
			if (req.cylinder < start_head) begin
				item_s1.key <= {1'b1, ~req.cylinder};
			end else begin
				item_s1.key <= {1'b0, req.cylinder};
			end
		end
	end

	assign push.valid = vld_s1;
	assign push.item  = item_s1;

endmodule

`default_nettype wire

[rtl/sds_queue.sv]
// Short FIFO between front and back so each side stalls on its own.
// Depends on sds_pkg. Depth must be a power of two (pointers wrap naturally).
`default_nettype none

module sds_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sds_pkg::q_xfer_t push,
	output logic                  push_ready,
	output sds_pkg::q_xfer_t      pop,
	input  wire logic             pop_ready
);
	import sds_pkg::*;

	q_item_t             ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign pop.valid  = cnt_q != '0;
	assign pop.item   = ent_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop.valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_ptr_q] <= push.item;
	end

endmodule

`default_nettype wire

[rtl/sds_back.sv]
// Back part: sorted insertion array of sort keys, then the service walk that
// emits visits with the running seek total. Depends on sds_pkg, sds_visit_if.
`default_nettype none

module sds_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sds_pkg::q_xfer_t pop,
	output logic                  pop_ready,
	input  wire sds_pkg::cyl_t    start_head,
	input  wire sds_pkg::cyl_t    max_cylinder,
	sds_visit_if.source           visit
);
	import sds_pkg::*;

	typedef enum logic {
		LOAD,
		EMIT
	} state_t;

	state_t state_q;
	key_t   key_q [MAX_REQUESTS];
	key_t   key_d [MAX_REQUESTS];
	cnt_t   count_q;
	cyl_t   head_q;
	seek_t  seek_q;
	logic   turned_q;

	logic   out_vld_q;
	cyl_t   out_cyl_q;
	seek_t  out_seek_q;
	logic   out_turn_q;
	logic   out_last_q;

	logic [MAX_REQUESTS-1:0] le;
	logic   take;
	logic   insert;
	logic   fire;
	logic   do_turn;
	cyl_t   target;
	cyl_t   diff;
	seek_t  seek_nxt;

	assign pop_ready = state_q == LOAD;
	assign take      = pop.valid && pop_ready;
	assign insert    = take && count_q < CNT_W'(MAX_REQUESTS);

	assign fire      = state_q == EMIT && (!out_vld_q || visit.ready);
	assign do_turn   = key_q[0][KEY_W-1] && !turned_q;
	assign target    = do_turn ? max_cylinder : key_to_cyl(key_q[0]);
	assign diff      = head_q > target ? head_q - target : target - head_q;
	assign seek_nxt  = seek_q + SEEK_W'(diff);

	// Each cell keeps, takes the new key, or takes its left neighbor's key on
	// insert; on a non-turn visit every cell but the last takes its right neighbor's key.
	always_comb begin
		for (int i = 0; i < MAX_REQUESTS; i++) begin
			le[i] = (CNT_W'(i) < count_q) && (key_q[i] <= pop.item.key);
		end
		for (int i = 0; i < MAX_REQUESTS; i++) begin
			key_d[i] = key_q[i];
			if (insert) begin
				if (le[i]) begin
					key_d[i] = key_q[i];
				end else if (i == 0) begin
					key_d[i] = pop.item.key;
				end else if (le[i-1]) begin
					key_d[i] = pop.item.key;
				end else begin
					key_d[i] = key_q[i-1];
				end
			end else if (fire && !do_turn && i < MAX_REQUESTS - 1) begin
				key_d[i] = key_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_REQUESTS; i++) begin
			key_q[i] <= key_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= LOAD;
			count_q   <= '0;
			turned_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				LOAD: begin
					if (insert) count_q <= count_q + 1'b1;
					if (take && pop.item.last) begin
						state_q  <= EMIT;
						turned_q <= 1'b0;
					end
				end
				EMIT: begin
					if (fire) begin
						if (do_turn) begin
							turned_q <= 1'b1;
						end else begin
							count_q <= count_q - 1'b1;
							if (count_q == CNT_W'(1)) state_q <= LOAD;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (visit.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && pop.item.last) begin
			head_q <= start_head;
			seek_q <= '0;
		end else if (fire) begin
			head_q     <= target;
			seek_q     <= seek_nxt;
			out_cyl_q  <= target;
			out_seek_q <= seek_nxt;
			out_turn_q <= do_turn;
			out_last_q <= !do_turn && count_q == CNT_W'(1);
		end
	end

	assign visit.valid          = out_vld_q;
	assign visit.visit_cylinder = out_cyl_q;
	assign visit.total_seek     = out_seek_q;
	assign visit.is_turn_point  = out_turn_q;
	assign visit.last_visit     = out_last_q;

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == EMIT |-> count_q != '0)
		else $error("service walk running on an empty store");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REQUESTS))
		else $error("request count past store size");

	a_turn_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_turn_q |-> !out_last_q)
		else $error("turn point flagged as final visit");

	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> key_q[0] <= key_q[1])
		else $error("sort array out of order");

	a_no_load_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == EMIT |=> !(fire && !do_turn && count_q == CNT_W'(1)) ||
			state_q == EMIT)
		else $error("walk state lost");

endmodule

`default_nettype wire

[rtl/scan_disk_scheduler.sv]
// Top level of the SCAN disk scheduler: configuration registers, front,
// queue and back. Depends on sds_pkg, sds_ifs, sds_front, sds_queue, sds_back.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        cylinder[11:0], last_request
//   visit    out  valid/ready        visit_cylinder[11:0], total_seek[18:0],
//                                    is_turn_point, last_visit
//   cfg      in   cfg_we (no wait)   cfg_index[0], cfg_data[11:0]
//
// Requests load one per cycle into a sorted insertion array of 32 cells. With front
// and queue empty, the final request passes both before the back registers the
// first visit; the rest follow one per cycle unless visit stalls, set by the
// single seek adder of the walk. The back takes no request while a schedule is
// walked; the front stage and the two-entry queue take three more, then the input
// stalls. Reset clears control state only; the store needs no clearing pass.
`default_nettype none

module scan_disk_scheduler (
	input  wire logic               clk,
	input  wire logic               arst_n,
	sds_req_if.sink                 req,
	sds_visit_if.source             visit,
	input  wire logic               cfg_we,
	input  wire sds_pkg::cfg_idx_t  cfg_index,
	input  wire sds_pkg::cyl_t      cfg_data
);
	import sds_pkg::*;

	cyl_t    start_head_q;
	cyl_t    max_cyl_q;
	q_xfer_t push;
	logic    push_ready;
	q_xfer_t pop;
	logic    pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_head_q <= '0;
			max_cyl_q    <= MAX_CYL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_HEAD: start_head_q <= cfg_data;
				REG_MAX_CYL:    max_cyl_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	sds_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.start_head (start_head_q),
		.push       (push),
		.push_ready (push_ready)
	);

	sds_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_ready  (pop_ready)
	);

	sds_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop          (pop),
		.pop_ready    (pop_ready),
		.start_head   (start_head_q),
		.max_cylinder (max_cyl_q),
		.visit        (visit)
	);

endmodule

`default_nettype wire

[dv/scan_disk_scheduler_tb.sv]
// Self-checking testbench for scan_disk_scheduler: request batches in, SCAN visit order out.
// Depends on sds_pkg and the channel interfaces in sds_ifs; a local predictor builds the
// expected visits per batch and a monitor checks them in order.
`default_nettype none

module scan_disk_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sds_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int END_CYCLES   = 50;
	localparam int HOLD_LENGTH  = 400;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		cyl_t cylinder;
		logic last;
	} request_t;

	typedef struct packed {
		cyl_t  cyl;
		seek_t seek;
		logic  turn;
		logic  last;
	} visit_t;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	cyl_t     cfg_data;

	sds_req_if   req_if ();
	sds_visit_if visit_if ();

	scan_disk_scheduler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.visit     (visit_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	request_t pending_requests[$];
	visit_t   expected_visits[$];
	int       n_queued;
	int       n_accepted;
	int       error_count;
	int       hold_cycles;
	bit       hold_done;
	int       cycle_count;

	// predictor state
	cyl_t head_start;
	cyl_t turn_cylinder;
	cyl_t request_store[MAX_REQUESTS];
	int   request_count;

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int sender_idle_pct();
		if (n_accepted < 100)
			return 30;
		else if (n_accepted < 200)
			return 50;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (n_accepted < 100)
			return 50;
		else if (n_accepted < 200)
			return 30;
		return 0;
	endfunction

	// Store the request if there is room; on the final one, sort the batch and emit the SCAN walk.
	function automatic void schedule_request(cyl_t cyl, logic last);
		cyl_t   sorted[MAX_REQUESTS];
		cyl_t   key;
		int     n, i, j, split, total, k;
		int     head, seek, target;
		visit_t vis;
		if (request_count < MAX_REQUESTS) begin
			request_store[request_count] = cyl;
			request_count++;
		end
		if (!last)
			return;
		n = request_count;
		request_count = 0;
		for (i = 0; i < n; i++) begin
			key = request_store[i];
			j = i;
			while (j > 0 && sorted[j-1] > key) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = key;
		end
		split = 0;
		while (split < n && sorted[split] < head_start)
			split++;
		total = n + ((split > 0) ? 1 : 0);
		head = head_start;
		seek = 0;
		k = 0;
		for (i = split; i < n; i++) begin
			target = sorted[i];
			seek += (head > target) ? head - target : target - head;
			head = target;
			vis = '{cyl: cyl_t'(head), seek: seek_t'(seek), turn: 1'b0, last: (k == total - 1)};
			expected_visits.push_back(vis);
			k++;
		end
		if (split > 0) begin
			target = turn_cylinder;
			seek += (head > target) ? head - target : target - head;
			head = target;
			vis = '{cyl: cyl_t'(head), seek: seek_t'(seek), turn: 1'b1, last: (k == total - 1)};
			expected_visits.push_back(vis);
			k++;
			for (i = split - 1; i >= 0; i--) begin
				target = sorted[i];
				seek += (head > target) ? head - target : target - head;
				head = target;
				vis = '{cyl: cyl_t'(head), seek: seek_t'(seek), turn: 1'b0,
					last: (k == total - 1)};
				expected_visits.push_back(vis);
				k++;
			end
		end
	endfunction

	always @(posedge clk) begin : request_driver
		request_t nxt;
		bit       offer;
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				schedule_request(req_if.cylinder, req_if.last_request);
				n_accepted++;
			end
			if (!req_if.valid || req_if.ready) begin
				// keep offering while the receiver is held off so the block backs up
				offer = (pending_requests.size() != 0) &&
					(hold_cycles != 0 || $urandom_range(99) >= sender_idle_pct());
				if (offer) begin
					nxt = pending_requests.pop_front();
					req_if.cylinder     <= nxt.cylinder;
					req_if.last_request <= nxt.last;
					req_if.valid        <= 1'b1;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : visit_monitor
		visit_t exp_v;
		bit     rdy;
		if (!arst_n) begin
			visit_if.ready <= 1'b0;
		end else begin
			if (visit_if.valid && visit_if.ready) begin
				if (expected_visits.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: unexpected visit cyl=%0d seek=%0d turn=%0b last=%0b",
							$realtime, visit_if.visit_cylinder, visit_if.total_seek,
							visit_if.is_turn_point, visit_if.last_visit);
				end else begin
					exp_v = expected_visits.pop_front();
					if (visit_if.visit_cylinder !== exp_v.cyl ||
						visit_if.total_seek !== exp_v.seek ||
						visit_if.is_turn_point !== exp_v.turn ||
						visit_if.last_visit !== exp_v.last) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display({"%0t: visit mismatch expected cyl=%0d seek=%0d turn=%0b",
								" last=%0b, got cyl=%0d seek=%0d turn=%0b last=%0b"},
								$realtime, exp_v.cyl, exp_v.seek, exp_v.turn, exp_v.last,
								visit_if.visit_cylinder, visit_if.total_seek,
								visit_if.is_turn_point, visit_if.last_visit);
					end
				end
			end
			if (!hold_done && n_accepted >= 150 && pending_requests.size() > 8) begin
				hold_cycles = HOLD_LENGTH;
				hold_done = 1'b1;
			end
			if (hold_cycles != 0) begin
				hold_cycles--;
				rdy = 1'b0;
			end else begin
				rdy = $urandom_range(99) >= receiver_idle_pct();
			end
			visit_if.ready <= rdy;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic add_request(input int cyl, input bit last);
		pending_requests.push_back('{cylinder: cyl_t'(cyl), last: last});
		n_queued++;
	endtask

	task automatic add_batch(input int n);
		int i, r, cyl;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 15)
				cyl = head_start;
			else if (r < 30)
				cyl = int'(head_start) + $urandom_range(6) - 3;
			else
				cyl = $urandom_range(4095);
			if (cyl < 0)
				cyl = 0;
			if (cyl > 4095)
				cyl = 4095;
			add_request(cyl, i == n - 1);
		end
	endtask

	// Hold stimulus until every queued request is taken and every visit has come.
	task automatic wait_idle(input int extra);
		while (n_accepted != n_queued || expected_visits.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_config(input int start, input int maxc);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_HEAD;
		cfg_data  <= cyl_t'(start);
		head_start = cyl_t'(start);
		@(posedge clk);
		cfg_index <= REG_MAX_CYL;
		cfg_data  <= cyl_t'(maxc);
		turn_cylinder = cyl_t'(maxc);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int phase, phase_items, size, r, start, maxc;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_START_HEAD;
		cfg_data            = '0;
		req_if.valid        = 1'b0;
		req_if.cylinder     = '0;
		req_if.last_request = 1'b0;
		visit_if.ready      = 1'b0;
		n_queued            = 0;
		n_accepted          = 0;
		error_count         = 0;
		hold_cycles         = 0;
		hold_done           = 1'b0;
		cycle_count         = 0;
		head_start          = '0;
		turn_cylinder       = MAX_CYL_RESET;
		request_count       = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// mixed batch: head hit, zero, top cylinder above the turn point
		write_config(100, 199);
		add_request(150, 0);
		add_request(120, 0);
		add_request(100, 0);
		add_request(30, 0);
		add_request(0, 0);
		add_request(4095, 1);
		add_request(5, 1);
		add_request(200, 1);
		wait_idle(DRAIN_CYCLES);

		// head at zero: nothing below, so no turn
		write_config(0, 1);
		add_request(4095, 0);
		add_request(0, 0);
		add_request(1, 0);
		add_request(4095, 1);
		wait_idle(DRAIN_CYCLES);

		// turn point equal to the head after the upper sweep
		write_config(4095, 4095);
		add_request(4095, 0);
		add_request(0, 0);
		add_request(2048, 1);
		add_request(7, 1);
		wait_idle(DRAIN_CYCLES);

		for (phase = 0; phase < 5; phase++) begin
			start = $urandom_range(4095);
			maxc  = $urandom_range(4095, 1);
			if (phase == 1) begin
				start = 4095;
				maxc  = 1;
			end else if (phase == 3) begin
				start = 0;
				maxc  = 4095;
			end
			write_config(start, maxc);
			phase_items = 0;
			// overflow the store at least once: extra requests are dropped
			if (phase == 2) begin
				add_batch(35);
				phase_items += 35;
			end
			while (phase_items < 40) begin
				r = $urandom_range(99);
				if (r < 8)
					size = $urandom_range(36, 33);
				else if (r < 30)
					size = $urandom_range(20, 9);
				else
					size = $urandom_range(8, 1);
				add_batch(size);
				phase_items += size;
			end
			wait_idle(DRAIN_CYCLES);
		end

		wait_idle(END_CYCLES);
		if (error_count == 0 && expected_visits.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
